@@ src/lpi_pkg.sv @@
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and sizing constants for the line and plane intersection block.
// ----------------------------------------------------------------------------
package lpi_pkg;

  // coordinate format, signed fixed point
  localparam int CW  = 32;
  localparam int FB  = 16;
  localparam int NZW = 17;

  // dot product widths: magnitudes and signed sums
  localparam int DW  = 2 * CW;
  localparam int SDW = 2 * CW + 1;
  localparam int EW  = 2 * CW + 1;
  localparam int SEW = 2 * CW + 2;
  localparam int NW  = EW + FB;

  // quotient: TW bits from the divider, TEW bits once clamped
  localparam int TW  = CW + FB + 1;
  localparam int TEW = TW + 1;
  localparam int TLO = TEW / 2;
  localparam int THI = TEW - TLO;

  // offset after the fraction shift, and the unsaturated hit point
  localparam int OW  = TEW + CW - FB;
  localparam int HW  = OW + 2;

  localparam logic [NZW-1:0] NZ_LIMIT_RESET = NZW'(66);

  // result classes
  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_IN_PLANE = 2'd2;

  typedef struct packed {
    logic [CW-1:0] line_point_x;
    logic [CW-1:0] line_point_y;
    logic [CW-1:0] line_point_z;
    logic [CW-1:0] line_dir_x;
    logic [CW-1:0] line_dir_y;
    logic [CW-1:0] line_dir_z;
    logic [CW-1:0] plane_point_x;
    logic [CW-1:0] plane_point_y;
    logic [CW-1:0] plane_point_z;
    logic [CW-1:0] plane_normal_x;
    logic [CW-1:0] plane_normal_y;
    logic [CW-1:0] plane_normal_z;
  } lpi_in_t;

  typedef struct packed {
    logic [1:0]    hit_status;
    logic [CW-1:0] hit_x;
    logic [CW-1:0] hit_y;
    logic [CW-1:0] hit_z;
    logic          overflow_flag;
  } lpi_out_t;

  // classified item handed from the front part to the back part
  typedef struct packed {
    logic [1:0]         status;
    logic               clamp;
    logic               tneg;
    logic [DW-1:0]      dmag;
    logic [DW-1:0]      rem;
    logic [TW-1:0]      nlo;
    logic [2:0][CW-1:0] pt;
    logic [2:0][CW-1:0] dir;
  } lpi_job_t;

endpackage

@@ src/lpi_front.sv @@
// ----------------------------------------------------------------------------
// lpi_front
// Takes items, forms both dot products and classifies each item against the
// near-zero limit; prepares the divider's starting remainder and clamp flag.
// ----------------------------------------------------------------------------
module lpi_front import lpi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  lpi_in_t        in_data,
  input  logic [NZW-1:0] nz_limit,
  output logic           job_push,
  output lpi_job_t       job,
  input  logic           job_full
);

  logic en_f;

  // stage 0: captured item and point differences
  logic                 v0_r;
  logic [2:0][CW-1:0]   pt0_r, dir0_r, nrm0_r;
  logic signed [CW:0]   diff0_r [3];
  logic [2:0][CW-1:0]   pt_in, dir_in, nrm_in, pl_in;
  logic signed [CW:0]   diff_nxt [3];

  // stage 1: products
  logic                   v1_r;
  logic [2:0][CW-1:0]     pt1_r, dir1_r;
  logic signed [2*CW-1:0] dprod1_r [3];
  logic signed [2*CW:0]   eprod1_r [3];
  logic signed [2*CW-1:0] dprod_nxt [3];
  logic signed [2*CW:0]   eprod_nxt [3];

  // stage 2: sums
  logic                  v2_r;
  logic [2:0][CW-1:0]    pt2_r, dir2_r;
  logic signed [SDW-1:0] dsum2_r;
  logic signed [SEW-1:0] esum2_r;
  logic signed [SDW-1:0] dsum_nxt;
  logic signed [SEW-1:0] esum_nxt;

  // classification
  logic [SDW-1:0] dneg;
  logic [SEW-1:0] eneg;
  logic [DW-1:0]  dmag;
  logic [EW-1:0]  emag;
  logic [EW-1:0]  thr;
  logic [NW-1:0]  num;
  logic [CW-1:0]  nhi;
  logic           d_small, e_small;

  // the whole front advances unless its last item cannot enter the queue
  assign en_f     = !v2_r || !job_full;
  assign in_full  = !en_f;
  assign job_push = v2_r && !job_full;

  // unpack and point differences
  always_comb begin
    pt_in  = {in_data.line_point_z, in_data.line_point_y, in_data.line_point_x};
    dir_in = {in_data.line_dir_z, in_data.line_dir_y, in_data.line_dir_x};
    pl_in  = {in_data.plane_point_z, in_data.plane_point_y, in_data.plane_point_x};
    nrm_in = {in_data.plane_normal_z, in_data.plane_normal_y, in_data.plane_normal_x};
    for (int i = 0; i < 3; i++) begin
      diff_nxt[i] = $signed({pl_in[i][CW-1], pl_in[i]}) - $signed({pt_in[i][CW-1], pt_in[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en_f) begin
      v0_r <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      pt0_r  <= pt_in;
      dir0_r <= dir_in;
      nrm0_r <= nrm_in;
      for (int i = 0; i < 3; i++) begin
        diff0_r[i] <= diff_nxt[i];
      end
    end
  end

  // per-axis products for both dot products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dprod_nxt[i] = $signed(dir0_r[i]) * $signed(nrm0_r[i]);
      eprod_nxt[i] = diff0_r[i] * $signed(nrm0_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en_f) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      pt1_r  <= pt0_r;
      dir1_r <= dir0_r;
      for (int i = 0; i < 3; i++) begin
        dprod1_r[i] <= dprod_nxt[i];
        eprod1_r[i] <= eprod_nxt[i];
      end
    end
  end

  // dot product sums
  assign dsum_nxt = dprod1_r[0] + dprod1_r[1] + dprod1_r[2];
  assign esum_nxt = eprod1_r[0] + eprod1_r[1] + eprod1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en_f) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      pt2_r   <= pt1_r;
      dir2_r  <= dir1_r;
      dsum2_r <= dsum_nxt;
      esum2_r <= esum_nxt;
    end
  end

  // magnitudes, near-zero tests and divider set-up
  always_comb begin
    dneg = -dsum2_r;
    eneg = -esum2_r;
    dmag = dsum2_r[SDW-1] ? dneg[DW-1:0] : dsum2_r[DW-1:0];
    emag = esum2_r[SEW-1] ? eneg[EW-1:0] : esum2_r[EW-1:0];
    thr  = {{(EW-NZW-FB){1'b0}}, nz_limit, {FB{1'b0}}};
    d_small = (dmag == '0) || ({1'b0, dmag} < thr);
    e_small = (emag == '0) || (emag < thr);
    num  = {emag, {FB{1'b0}}};
    nhi  = num[NW-1:TW];

    job.status = d_small ? (e_small ? ST_IN_PLANE : ST_PARALLEL) : ST_HIT;
    // quotient at or beyond the cap whenever the top numerator bits reach the divisor
    job.clamp  = {{(DW-CW){1'b0}}, nhi} >= dmag;
    job.tneg   = dsum2_r[SDW-1] ^ esum2_r[SEW-1];
    job.dmag   = dmag;
    job.rem    = {{(DW-CW){1'b0}}, nhi};
    job.nlo    = num[TW-1:0];
    job.pt     = pt2_r;
    job.dir    = dir2_r;
  end

endmodule

@@ src/lpi_queue.sv @@
// ----------------------------------------------------------------------------
// lpi_queue
// Short first-in first-out buffer of classified items between front and back.
// ----------------------------------------------------------------------------
module lpi_queue import lpi_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  lpi_job_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output lpi_job_t rd_data,
  output logic     empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lpi_job_t      slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic [AW-1:0] wp_nxt, rp_nxt;
  logic [AW:0]   cnt_nxt;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = slot_r[rp_r];

  // pointer wrap and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

@@ src/lpi_back.sv @@
// ----------------------------------------------------------------------------
// lpi_back
// Pipelined restoring divider for the line parameter, split product with the
// direction, offset add and saturation, and the result register.
// ----------------------------------------------------------------------------
module lpi_back import lpi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_empty,
  output logic     job_pop,
  input  lpi_job_t job,
  input  logic     out_pop,
  output logic     out_empty,
  output lpi_out_t out_data
);

  logic en_b;

  // divider stages, one quotient bit each
  lpi_job_t      dv_job_r [TW];
  logic [TW-1:0] dv_q_r [TW];
  logic          dv_v_r [TW];
  lpi_job_t      st_in [TW];
  logic [TW-1:0] stq_in [TW];
  logic          stv_in [TW];

  // product stage
  logic                     m_v_r;
  logic [1:0]               m_status_r;
  logic [2:0][CW-1:0]       m_pt_r;
  logic [2:0]               m_neg_r;
  logic [2:0][TLO+CW-1:0]   m_plo_r;
  logic [2:0][THI+CW-1:0]   m_phi_r;
  lpi_job_t                 last;
  logic [TEW-1:0]           teff;
  logic [CW-1:0]            lneg_v;
  logic [2:0][CW-1:0]       lmag;
  logic [2:0]               neg_nxt;
  logic [2:0][TLO+CW-1:0]   plo_nxt;
  logic [2:0][THI+CW-1:0]   phi_nxt;

  // result stage
  logic                     o_v_r;
  lpi_out_t                 o_data_r;
  lpi_out_t                 o_data_nxt;
  logic [TEW+CW-1:0]        off;
  logic [OW-1:0]            off_sh;
  logic [HW-1:0]            pext, oext, hit;
  logic [2:0][CW-1:0]       res;
  logic [2:0]               sat;

  // whole back part advances while the result register can move on
  assign en_b      = !o_v_r || out_pop;
  assign job_pop   = en_b && !job_empty;
  assign out_empty = !o_v_r;
  assign out_data  = o_data_r;

  assign st_in[0]  = job;
  assign stq_in[0] = '0;
  assign stv_in[0] = !job_empty;

  for (genvar k = 0; k < TW; k++) begin : g_div
    logic [DW:0]   r_sh, r_sub;
    logic          ge;
    lpi_job_t      dv_job_nxt;
    logic [TW-1:0] dv_q_nxt;

    if (k > 0) begin : g_link
      assign st_in[k]  = dv_job_r[k-1];
      assign stq_in[k] = dv_q_r[k-1];
      assign stv_in[k] = dv_v_r[k-1];
    end

    // shift in one numerator bit, subtract the divisor where it fits
    always_comb begin
      r_sh  = {st_in[k].rem, st_in[k].nlo[TW-1]};
      r_sub = r_sh - {1'b0, st_in[k].dmag};
      ge    = r_sh >= {1'b0, st_in[k].dmag};
      dv_job_nxt      = st_in[k];
      dv_job_nxt.rem  = ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
      dv_job_nxt.nlo  = {st_in[k].nlo[TW-2:0], 1'b0};
      dv_q_nxt        = {stq_in[k][TW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (en_b) begin
        dv_v_r[k] <= stv_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en_b) begin
        dv_job_r[k] <= dv_job_nxt;
        dv_q_r[k]   <= dv_q_nxt;
      end
    end
  end

  // clamp the quotient and multiply by the direction magnitude in two halves
  always_comb begin
    last = dv_job_r[TW-1];
    teff = last.clamp ? {1'b1, {TW{1'b0}}} : {1'b0, dv_q_r[TW-1]};
    for (int i = 0; i < 3; i++) begin
      lneg_v     = -last.dir[i];
      lmag[i]    = last.dir[i][CW-1] ? lneg_v : last.dir[i];
      neg_nxt[i] = last.tneg ^ last.dir[i][CW-1];
      plo_nxt[i] = teff[TLO-1:0] * lmag[i];
      phi_nxt[i] = teff[TEW-1:TLO] * lmag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en_b) begin
      m_v_r <= dv_v_r[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      m_status_r <= last.status;
      m_pt_r     <= last.pt;
      m_neg_r    <= neg_nxt;
      m_plo_r    <= plo_nxt;
      m_phi_r    <= phi_nxt;
    end
  end

  // offset, add to the line point, saturate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off    = {m_phi_r[i], {TLO{1'b0}}} + {{THI{1'b0}}, m_plo_r[i]};
      off_sh = off[TEW+CW-1:FB];
      pext   = {{(HW-CW){m_pt_r[i][CW-1]}}, m_pt_r[i]};
      oext   = {2'b00, off_sh};
      hit    = m_neg_r[i] ? pext - oext : pext + oext;
      if ((&hit[HW-1:CW-1]) || !(|hit[HW-1:CW-1])) begin
        res[i] = hit[CW-1:0];
        sat[i] = 1'b0;
      end else begin
        res[i] = hit[HW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        sat[i] = 1'b1;
      end
    end
    o_data_nxt.hit_status = m_status_r;
    if (m_status_r == ST_HIT) begin
      o_data_nxt.hit_x         = res[0];
      o_data_nxt.hit_y         = res[1];
      o_data_nxt.hit_z         = res[2];
      o_data_nxt.overflow_flag = |sat;
    end else begin
      o_data_nxt.hit_x         = '0;
      o_data_nxt.hit_y         = '0;
      o_data_nxt.hit_z         = '0;
      o_data_nxt.overflow_flag = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en_b) begin
      o_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      o_data_r <= o_data_nxt;
    end
  end

endmodule

@@ src/line_plane_intersection.sv @@
// Throughput: one item per cycle while the result side does not stall; the divider
// is a 49-stage pipeline giving one quotient bit per stage, and every other unit is
// pipelined at the same rate.
// Reset: synchronous, active low; empties the queue and all pipeline valid flags
// and sets near_zero_limit to 66. No clearing pass is needed.
// ----------------------------------------------------------------------------
// line_plane_intersection
// Intersects a fixed-point line with a plane: classifies near-parallel lines,
// otherwise divides the dot products and gives the saturated hit point.
// ----------------------------------------------------------------------------
module line_plane_intersection import lpi_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  lpi_in_t        in_data,
  output logic           empty,
  input  logic           pop,
  output lpi_out_t       out_data,
  input  logic           cfg_we,
  input  logic [NZW-1:0] cfg_wdata
);

  logic [NZW-1:0] nz_limit_r;
  logic           job_push, job_full, job_pop, job_empty;
  lpi_job_t       job_wr, job_rd;

  // near-zero limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_limit_r <= NZ_LIMIT_RESET;
    end else if (cfg_we) begin
      nz_limit_r <= cfg_wdata;
    end
  end

  // dot products and classification
  lpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (push),
    .in_full  (full),
    .in_data  (in_data),
    .nz_limit (nz_limit_r),
    .job_push (job_push),
    .job      (job_wr),
    .job_full (job_full)
  );

  // decoupling queue
  lpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  // division, hit point and result register
  lpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_rd),
    .out_pop   (pop),
    .out_empty (empty),
    .out_data  (out_data)
  );

endmodule

@@ bench/lpi_checker.sv @@
// ----------------------------------------------------------------------------
// lpi_checker
// Watches the item and result channels of the line and plane intersection
// block, predicts each result from the accepted item and the current
// near-zero limit, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module lpi_checker import lpi_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic           full,
  input  lpi_in_t        in_data,
  input  logic           empty,
  input  logic           pop,
  input  lpi_out_t       out_data,
  input  logic           cfg_we,
  input  logic [NZW-1:0] cfg_wdata,
  output int             n_errors,
  output int             n_pending,
  output int             n_checked,
  output int             n_hits,
  output int             n_saturated,
  output int             n_parallel,
  output int             n_in_plane
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [127:0] T_CAP     = 128'sd1 <<< (CW + FB + 1);
  localparam logic signed [127:0] COORD_MAX = (128'sd1 <<< (CW - 1)) - 128'sd1;
  localparam logic signed [127:0] COORD_MIN = -(128'sd1 <<< (CW - 1));

  logic [NZW-1:0] nz_limit;
  lpi_out_t       hits_due[$];

  // exact-width prediction of one item's result
  function automatic lpi_out_t predict_result(lpi_in_t it, logic [NZW-1:0] lim);
    logic signed [127:0] p [3];
    logic signed [127:0] l [3];
    logic signed [127:0] q [3];
    logic signed [127:0] n [3];
    logic signed [127:0] d_ln, d_pn, mag_ln, mag_pn, thr, t, off, pos;
    logic [2:0][CW-1:0] xyz;
    logic t_neg, l_neg, sat;
    lpi_out_t r;
    p[0] = $signed(it.line_point_x);
    p[1] = $signed(it.line_point_y);
    p[2] = $signed(it.line_point_z);
    l[0] = $signed(it.line_dir_x);
    l[1] = $signed(it.line_dir_y);
    l[2] = $signed(it.line_dir_z);
    q[0] = $signed(it.plane_point_x);
    q[1] = $signed(it.plane_point_y);
    q[2] = $signed(it.plane_point_z);
    n[0] = $signed(it.plane_normal_x);
    n[1] = $signed(it.plane_normal_y);
    n[2] = $signed(it.plane_normal_z);
    d_ln = l[0] * n[0] + l[1] * n[1] + l[2] * n[2];
    d_pn = (q[0] - p[0]) * n[0] + (q[1] - p[1]) * n[1] + (q[2] - p[2]) * n[2];
    mag_ln = (d_ln < 0) ? -d_ln : d_ln;
    mag_pn = (d_pn < 0) ? -d_pn : d_pn;
    thr = 128'(lim) << FB;
    r = '0;
    // near-zero direction dot product: no single crossing point
    if (mag_ln == 0 || mag_ln < thr) begin
      r.hit_status = (mag_pn == 0 || mag_pn < thr) ? ST_IN_PLANE : ST_PARALLEL;
      return r;
    end
    // quotient truncated, magnitude clamped
    t = (mag_pn <<< FB) / mag_ln;
    if (t > T_CAP) t = T_CAP;
    t_neg = (d_ln < 0) != (d_pn < 0);
    sat = 1'b0;
    // per axis offset truncated on magnitude, then saturated sum
    for (int i = 0; i < 3; i++) begin
      l_neg = l[i] < 0;
      off = (t * (l_neg ? -l[i] : l[i])) >>> FB;
      if (t_neg != l_neg) off = -off;
      pos = p[i] + off;
      if (pos < COORD_MIN) begin
        xyz[i] = COORD_MIN[CW-1:0];
        sat = 1'b1;
      end else if (pos > COORD_MAX) begin
        xyz[i] = COORD_MAX[CW-1:0];
        sat = 1'b1;
      end else begin
        xyz[i] = pos[CW-1:0];
      end
    end
    r.hit_status    = ST_HIT;
    r.hit_x         = xyz[0];
    r.hit_y         = xyz[1];
    r.hit_z         = xyz[2];
    r.overflow_flag = sat;
    return r;
  endfunction

  function automatic int field_diff(string name, logic [CW-1:0] want_v, logic [CW-1:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // channel monitor
  always @(posedge clk) begin : watch
    lpi_out_t want;
    int bad;
    if (!rst_n) begin
      nz_limit <= NZ_LIMIT_RESET;
      hits_due.delete();
      n_pending <= 0;
    end else begin
      bad = 0;
      // result side first: an item taken at this edge cannot also leave at it
      if (pop && !empty) begin
        if (hits_due.size() == 0) begin
          $error("result item with nothing expected: status %0d x %0h y %0h z %0h",
                 out_data.hit_status, out_data.hit_x, out_data.hit_y, out_data.hit_z);
          bad++;
        end else begin
          want = hits_due.pop_front();
          bad += field_diff("hit_status", want.hit_status, out_data.hit_status);
          bad += field_diff("hit_x", want.hit_x, out_data.hit_x);
          bad += field_diff("hit_y", want.hit_y, out_data.hit_y);
          bad += field_diff("hit_z", want.hit_z, out_data.hit_z);
          bad += field_diff("overflow_flag", want.overflow_flag, out_data.overflow_flag);
          n_checked <= n_checked + 1;
          case (want.hit_status)
            ST_HIT:      n_hits <= n_hits + 1;
            ST_PARALLEL: n_parallel <= n_parallel + 1;
            default:     n_in_plane <= n_in_plane + 1;
          endcase
          if (want.overflow_flag) n_saturated <= n_saturated + 1;
        end
      end
      if (push && !full) hits_due.push_back(predict_result(in_data, nz_limit));
      if (cfg_we) nz_limit <= cfg_wdata;
      n_errors  <= n_errors + bad;
      n_pending <= hits_due.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random line/plane items into line_plane_intersection
// under several near-zero limits and idle patterns; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench import lpi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef int vec3_t [3];

  localparam int ONE  = 65536;
  localparam int MAXV = 32'sh7FFF_FFFF;
  localparam int MINV = 32'sh8000_0000;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           push      = 1'b0;
  lpi_in_t        in_data   = '0;
  logic           pop       = 1'b0;
  logic           cfg_we    = 1'b0;
  logic [NZW-1:0] cfg_wdata = '0;
  logic           full;
  logic           empty;
  lpi_out_t       out_data;

  int n_errors, n_pending, n_checked, n_hits, n_saturated, n_parallel, n_in_plane;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_settings  = 1;
  int n_items     = 0;

  line_plane_intersection u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  lpi_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_data     (in_data),
    .empty       (empty),
    .pop         (pop),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_checked   (n_checked),
    .n_hits      (n_hits),
    .n_saturated (n_saturated),
    .n_parallel  (n_parallel),
    .n_in_plane  (n_in_plane)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // random value in [-2^bits, 2^bits)
  function automatic int span(int bits);
    int v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  function automatic int pick_edge();
    case ($urandom_range(6))
      0:       return MINV;
      1:       return MAXV;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      5:       return ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic lpi_in_t pack_item(vec3_t p, vec3_t l, vec3_t q, vec3_t n);
    return '{p[0], p[1], p[2], l[0], l[1], l[2], q[0], q[1], q[2], n[0], n[1], n[2]};
  endfunction

  // one random line/plane pair, shaped towards hits, parallels and edges
  function automatic lpi_in_t random_ray_plane();
    vec3_t p, l, q, n, w, d;
    int kind, s, k;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      p[i] = $urandom;
      l[i] = $urandom;
      q[i] = $urandom;
      n[i] = $urandom;
      w[i] = span(14);
      d[i] = 0;
    end
    case (kind)
      0, 1: ;
      2, 3, 4: begin
        for (int i = 0; i < 3; i++) begin
          p[i] = span(21);
          q[i] = span(21);
          l[i] = span(18);
          n[i] = span(18);
        end
      end
      5: begin
        for (int i = 0; i < 3; i++) begin
          p[i] = span(27);
          q[i] = span(27);
          l[i] = span(27);
          n[i] = span(27);
        end
      end
      6, 7, 8: begin
        for (int i = 0; i < 3; i++) begin
          n[i] = span(14);
          q[i] = span(20);
          if (kind == 7) d[i] = span(8);
          if (kind == 8) d[i] = span(16);
        end
        // direction across the normal, so its dot product is exactly zero
        l[0] = n[1] * w[2] - n[2] * w[1];
        l[1] = n[2] * w[0] - n[0] * w[2];
        l[2] = n[0] * w[1] - n[1] * w[0];
        s = span(1);
        for (int i = 0; i < 3; i++) p[i] = q[i] + s * l[i] + d[i];
        // nudge one component for a tiny nonzero dot product
        if (kind == 8) begin
          k = $urandom_range(2);
          l[k] += span(4);
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          p[i] = pick_edge();
          l[i] = pick_edge();
          q[i] = pick_edge();
          n[i] = pick_edge();
        end
      end
    endcase
    return pack_item(p, l, q, n);
  endfunction

  // hand one item over, idling at random beforehand
  task automatic send_item(lpi_in_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
  endtask

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) send_item(random_ray_plane());
  endtask

  // stop sending and wait until every expected result has come back
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [NZW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 35;
    rx_idle_pct = 77;

    // directed items at the reset limit
    send_item(pack_item('{0, 0, 0}, '{0, 0, ONE}, '{0, 0, 5 * ONE}, '{0, 0, ONE}));
    send_item(pack_item('{ONE, 2 * ONE, 3 * ONE}, '{ONE, ONE, ONE}, '{0, 0, 0},
                        '{0, 0, ONE}));
    send_item(pack_item('{ONE + 123, -777, 4}, '{3 * ONE, -ONE, 12345},
                        '{0, 0, -2 * ONE + 7}, '{11111, -22222, ONE}));
    // parallel off the plane, and lying in it
    send_item(pack_item('{0, 0, ONE}, '{ONE, 0, 0}, '{0, 0, 0}, '{0, 0, ONE}));
    send_item(pack_item('{3, 4, 0}, '{ONE, 2 * ONE, 0}, '{0, 0, 0}, '{0, 0, ONE}));
    // one below the threshold, then exactly on it
    send_item(pack_item('{0, 0, 0}, '{66 * ONE - 1, 0, 0}, '{1, 0, 0}, '{1, 0, 0}));
    send_item(pack_item('{0, 0, 0}, '{66 * ONE - 1, 0, 0}, '{MAXV, 0, 0}, '{1, 0, 0}));
    send_item(pack_item('{0, 0, 0}, '{66 * ONE, 0, 0}, '{ONE, 0, 0}, '{1, 0, 0}));
    // saturation both ways, and the clamped quotient
    send_item(pack_item('{0, 0, 0}, '{MAXV, MINV, 66 * ONE}, '{0, 0, MAXV}, '{0, 0, 1}));
    send_item(pack_item('{MINV, MINV, MINV}, '{66 * ONE, 0, 0}, '{MAXV, MAXV, MAXV},
                        '{1, MAXV, MAXV}));
    // field extremes
    send_item(pack_item('{MINV, MINV, MINV}, '{MINV, MINV, MINV}, '{MINV, MINV, MINV},
                        '{MINV, MINV, MINV}));
    send_item(pack_item('{MAXV, MAXV, MAXV}, '{MAXV, MAXV, MAXV}, '{MAXV, MAXV, MAXV},
                        '{MAXV, MAXV, MAXV}));
    send_item(pack_item('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    send_item(pack_item('{MAXV, MINV, MAXV}, '{MINV, MAXV, MINV}, '{MINV, MAXV, MINV},
                        '{MAXV, MINV, MAXV}));
    send_item(pack_item('{MINV, 0, 0}, '{1, 0, 0}, '{MAXV, 0, 0}, '{1, 0, 0}));
    send_item(pack_item('{-1, -1, -1}, '{-1, -ONE, ONE}, '{ONE, -ONE, 7}, '{-ONE, ONE, -1}));
    run_random(300);

    // zero limit: only an exact zero counts as zero
    wait_idle();
    write_limit('0);
    send_item(pack_item('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}));
    send_item(pack_item('{0, 0, 1}, '{1, 0, 0}, '{0, 0, 0}, '{0, 0, 1}));
    send_item(pack_item('{0, 0, 0}, '{1, 0, 0}, '{0, 0, MINV}, '{1, 0, 1}));
    send_item(pack_item('{0, 0, 0}, '{1, 0, 0}, '{0, 0, MAXV}, '{1, 0, MAXV}));
    run_random(280);

    // limit of 65536
    wait_idle();
    write_limit(NZW'(65536));
    send_item(pack_item('{0, 0, 0}, '{ONE - 1, 0, 0}, '{ONE - 1, 0, 0}, '{ONE, 0, 0}));
    send_item(pack_item('{0, 0, 0}, '{ONE, 0, 0}, '{ONE, 0, 0}, '{ONE, 0, 0}));
    run_random(280);

    // sender and receiver idling swapped
    tx_idle_pct = 77;
    rx_idle_pct = 35;
    wait_idle();
    write_limit(NZW'($urandom_range(65536)));
    run_random(280);
    wait_idle();
    write_limit(NZW'(1));
    run_random(140);

    // no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_idle();
    write_limit(NZW'($urandom_range(200)));
    run_random(140);

    // drain, then let any stray result show up
    wait_idle();
    repeat (60) @(posedge clk);
    $display("%0d items under %0d threshold settings, %0d results checked",
             n_items, n_settings, n_checked);
    $display("%0d hits (%0d saturated), %0d parallel, %0d in plane",
             n_hits, n_saturated, n_parallel, n_in_plane);
    if (n_errors == 0 && n_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
